### hdl/tifv_pkg.sv
`timescale 1ns / 1ps

package tifv_pkg;

  // fixed field widths
  localparam int COORD_W    = 9;
  localparam int GRID_W     = 10;
  localparam int RAD_W      = 14;
  localparam int FIELD_W    = 29;
  localparam int INDEX_W    = 27;

  // x^2 + y^2 of centred coordinates, |c| <= 511
  localparam int SUMSQ_W    = 19;
  // z^2 of a centred coordinate
  localparam int CZSQ_W     = 18;
  // centred coordinate, signed
  localparam int CENT_W     = 11;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  localparam int MAX_GRID_DEF  = 512;
  localparam int FRAC_BITS_DEF = 4;

  localparam logic [GRID_W-1:0] GRID_SIZE_RST    = 10'd256;
  localparam logic [RAD_W-1:0]  OUTER_RADIUS_RST = 14'd1280;
  localparam logic [RAD_W-1:0]  TUBE_RADIUS_RST  = 14'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE    = 2'd0,
    CFG_OUTER_RADIUS = 2'd1,
    CFG_TUBE_RADIUS  = 2'd2
  } cfg_reg_e;

  // per-voxel data carried alongside the root cells
  typedef struct packed {
    logic                  oor;
    logic [INDEX_W-1:0]    idx;
    logic [CZSQ_W-1:0]     cz_sq;
  } side_t;

  // bits of the truncated root of (x^2 + y^2) << 2*frac
  function automatic int root_w(int frac);
    return (SUMSQ_W + 2 * frac + 1) >> 1;
  endfunction

endpackage

### hdl/tifv_prep.sv
`timescale 1ns / 1ps

module tifv_prep
  import tifv_pkg::*;
#(
  parameter int MAX_GRID  = MAX_GRID_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [GRID_W-1:0]                grid_size_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [COORD_W-1:0]               coord_x_i,
  input  logic [COORD_W-1:0]               coord_y_i,
  input  logic [COORD_W-1:0]               coord_z_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [2*root_w(FRAC_BITS)-1:0]   rad_o,
  output side_t                            side_o
);

  localparam int RadW  = 2 * root_w(FRAC_BITS);
  localparam int SsW   = 2 * GRID_W;
  localparam int SyW   = GRID_W + COORD_W;
  localparam int IdxFW = SsW + COORD_W;
  localparam int CapV  = (MAX_GRID > (2**GRID_W - 1)) ? (2**GRID_W - 1) : MAX_GRID;
  localparam logic [GRID_W-1:0] SizeCap = GRID_W'(CapV);

  // stage one: centring, range check, size products
  logic                     p1_valid_q;
  logic                     p1_ready;
  logic                     oor_q, oor_d;
  logic signed [CENT_W-1:0] cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  logic [COORD_W-1:0]       x_q, z_q;
  logic [SsW-1:0]           ss_q, ss_d;
  logic [SyW-1:0]           sy_q, sy_d;
  logic [GRID_W-1:0]        size;
  logic [GRID_W-2:0]        half;

  // stage two: squares and linear index
  logic                     p2_valid_q;
  logic                     p2_ready;
  logic [RadW-1:0]          rad_q, rad_d;
  side_t                    side_q, side_d;
  logic signed [2*CENT_W-1:0] sqx, sqy, sqz;
  logic [SUMSQ_W-1:0]       sumsq;
  logic [IdxFW-1:0]         idx_full;

  assign p2_ready = !p2_valid_q || ready_i;
  assign p1_ready = !p1_valid_q || p2_ready;
  assign ready_o  = p1_ready;

  always_comb begin
    size  = (grid_size_i > SizeCap) ? SizeCap : grid_size_i;
    half  = size[GRID_W-1:1];
    oor_d = ({1'b0, coord_x_i} >= size) || ({1'b0, coord_y_i} >= size) ||
            ({1'b0, coord_z_i} >= size);
    cx_d  = $signed({2'b00, coord_x_i}) - $signed({2'b00, half});
    cy_d  = $signed({2'b00, coord_y_i}) - $signed({2'b00, half});
    cz_d  = $signed({2'b00, coord_z_i}) - $signed({2'b00, half});
    ss_d  = size * size;
    sy_d  = size * coord_y_i;
  end

  always_comb begin
    sqx          = cx_q * cx_q;
    sqy          = cy_q * cy_q;
    sqz          = cz_q * cz_q;
    sumsq        = SUMSQ_W'(sqx) + SUMSQ_W'(sqy);
    rad_d        = RadW'(sumsq) << (2 * FRAC_BITS);
    idx_full     = ss_q * x_q + IdxFW'(sy_q) + IdxFW'(z_q);
    side_d.oor   = oor_q;
    side_d.idx   = idx_full[INDEX_W-1:0];
    side_d.cz_sq = sqz[CZSQ_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      if (p1_ready) p1_valid_q <= valid_i;
      if (p2_ready) p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && p1_ready) begin
      oor_q <= oor_d;
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      cz_q  <= cz_d;
      x_q   <= coord_x_i;
      z_q   <= coord_z_i;
      ss_q  <= ss_d;
      sy_q  <= sy_d;
    end
    if (p1_valid_q && p2_ready) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = p2_valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

### hdl/tifv_root_cell.sv
`timescale 1ns / 1ps

module tifv_root_cell
  import tifv_pkg::*;
#(
  parameter int ROOT_W = root_w(FRAC_BITS_DEF)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [ROOT_W+1:0]    rem_i,
  input  logic [ROOT_W-1:0]    root_i,
  input  logic [2*ROOT_W-1:0]  rad_i,
  input  side_t                side_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [ROOT_W+1:0]    rem_o,
  output logic [ROOT_W-1:0]    root_o,
  output logic [2*ROOT_W-1:0]  rad_o,
  output side_t                side_o
);

  localparam int RemW = ROOT_W + 2;
  localparam int RadW = 2 * ROOT_W;

  logic                valid_q;
  logic                ready;
  logic [RemW+1:0]     acc, trial, diff;
  logic                take;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [RadW-1:0]     rad_q, rad_d;
  side_t               side_q;

  assign ready   = !valid_q || ready_i;
  assign ready_o = ready;

  // one result bit: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    acc    = {rem_i, rad_i[RadW-1 -: 2]};
    trial  = (RemW + 2)'({root_i, 2'b01});
    take   = (acc >= trial);
    diff   = acc - trial;
    rem_d  = take ? diff[RemW-1:0] : acc[RemW-1:0];
    root_d = {root_i[ROOT_W-2:0], take};
    rad_d  = rad_i << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

### hdl/tifv_field.sv
`timescale 1ns / 1ps

module tifv_field
  import tifv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ROOT_W    = root_w(FRAC_BITS_DEF)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [RAD_W-1:0]           outer_radius_i,
  input  logic [RAD_W-1:0]           tube_radius_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [ROOT_W-1:0]          root_i,
  input  side_t                      side_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [FIELD_W-1:0]  field_value_o,
  output logic [INDEX_W-1:0]         voxel_index_o,
  output logic                       out_of_range_o
);

  localparam int DW   = ((ROOT_W > RAD_W) ? ROOT_W : RAD_W) + 1;
  localparam int DdW  = 2 * DW;
  localparam int RrW  = 2 * RAD_W;
  localparam int CzsW = CZSQ_W + 2 * FRAC_BITS;
  localparam int FW   = DdW + 2;
  localparam int HiW  = FW - FIELD_W + 1;

  // stage one: squares
  logic                    t1_valid_q;
  logic                    t1_ready;
  logic signed [DW-1:0]    d;
  logic signed [DdW-1:0]   dd_q, dd_d;
  logic [RrW-1:0]          rr_q, rr_d;
  logic [CzsW-1:0]         czs_q, czs_d;
  logic [INDEX_W-1:0]      idx_q;
  logic                    oor_q;

  // stage two: difference, saturation, out-of-grid zeroing
  logic                       t2_valid_q;
  logic                       t2_ready;
  logic signed [FW-1:0]       f;
  logic [HiW-1:0]             hi;
  logic [FIELD_W-1:0]         sat;
  logic signed [FIELD_W-1:0]  field_q, field_d;
  logic [INDEX_W-1:0]         vidx_q, vidx_d;
  logic                       flag_q;

  assign t2_ready = !t2_valid_q || ready_i;
  assign t1_ready = !t1_valid_q || t2_ready;
  assign ready_o  = t1_ready;

  always_comb begin
    d     = $signed(DW'(outer_radius_i)) - $signed(DW'(root_i));
    dd_d  = d * d;
    rr_d  = tube_radius_i * tube_radius_i;
    czs_d = CzsW'(side_i.cz_sq) << (2 * FRAC_BITS);
  end

  always_comb begin
    f  = $signed(FW'(rr_q)) - FW'(dd_q) - $signed(FW'(czs_q));
    hi = f[FW-1:FIELD_W-1];
    if ((&hi) || !(|hi)) begin
      sat = f[FIELD_W-1:0];
    end else if (f[FW-1]) begin
      sat = {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(FIELD_W-1){1'b1}}};
    end
    field_d = oor_q ? '0 : $signed(sat);
    vidx_d  = oor_q ? '0 : idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
    end else begin
      if (t1_ready) t1_valid_q <= valid_i;
      if (t2_ready) t2_valid_q <= t1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && t1_ready) begin
      dd_q  <= dd_d;
      rr_q  <= rr_d;
      czs_q <= czs_d;
      idx_q <= side_i.idx;
      oor_q <= side_i.oor;
    end
    if (t1_valid_q && t2_ready) begin
      field_q <= field_d;
      vidx_q  <= vidx_d;
      flag_q  <= oor_q;
    end
  end

  assign valid_o        = t2_valid_q;
  assign field_value_o  = field_q;
  assign voxel_index_o  = vidx_q;
  assign out_of_range_o = flag_q;

endmodule

### hdl/torus_implicit_field_voxel.sv
`timescale 1ns / 1ps

// torus implicit field voxel generator. each input beat carries one voxel
// coordinate (x, y, z); each output beat carries the torus field value
// r^2 - (R - sqrt(X^2 + Y^2))^2 - Z^2 at that voxel, X, Y, Z being the
// coordinates centred on floor(grid_size / 2), together with the linear
// address grid_size^2 * x + grid_size * y + z. radii are unsigned fixed point
// with FRAC_BITS fractional bits, the root is truncated to FRAC_BITS
// fractional bits and the field value carries 2 * FRAC_BITS fractional bits,
// saturated to 29 bits signed. a coordinate at or beyond the grid size sets
// out_of_range and zeroes value and address; a grid size above MAX_GRID is
// clamped. one voxel is taken per clock and one result leaves per clock while
// the output is not stalled; the pipeline is the row of root cells that resolve
// one root bit each, behind two front stages (centring, squares) and two back
// stages (d^2, difference). every stage holds its own beat, so the input keeps
// being taken while a finished result waits on m_axis_tready, until every
// stage holds a beat. configuration is taken on every cycle and must only
// change while no voxel is in flight.

module torus_implicit_field_voxel
  import tifv_pkg::*;
#(
  parameter int MAX_GRID  = MAX_GRID_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // voxel coordinates
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // coord_x, coord_y, coord_z
  // field results
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // field_value, voxel_index
  output logic                    m_axis_tuser    // out_of_range
);

  localparam int RootW = root_w(FRAC_BITS);
  localparam int RemW  = RootW + 2;
  localparam int RadW  = 2 * RootW;

  // configuration registers
  logic [GRID_W-1:0]  grid_size_q;
  logic [RAD_W-1:0]   outer_radius_q;
  logic [RAD_W-1:0]   tube_radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q    <= GRID_SIZE_RST;
      outer_radius_q <= OUTER_RADIUS_RST;
      tube_radius_q  <= TUBE_RADIUS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GRID_SIZE:    grid_size_q    <= cfg_data_i[GRID_W-1:0];
        CFG_OUTER_RADIUS: outer_radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_TUBE_RADIUS:  tube_radius_q  <= cfg_data_i[RAD_W-1:0];
        default: ;  // unknown register, write dropped
      endcase
    end
  end

  // chain links: link 0 is the front end, link k+1 the output of root cell k
  logic               lk_valid [RootW+1];
  logic               lk_ready [RootW+1];
  logic [RemW-1:0]    lk_rem   [RootW+1];
  logic [RootW-1:0]   lk_root  [RootW+1];
  logic [RadW-1:0]    lk_rad   [RootW+1];
  side_t              lk_side  [RootW+1];

  // front end: centring, range check, squares and linear address
  tifv_prep #(
    .MAX_GRID  (MAX_GRID),
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_size_i (grid_size_q),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .coord_x_i   (s_axis_tdata[COORD_W-1:0]),
    .coord_y_i   (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .coord_z_i   (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
    .valid_o     (lk_valid[0]),
    .ready_i     (lk_ready[0]),
    .rad_o       (lk_rad[0]),
    .side_o      (lk_side[0])
  );

  // root search starts from an empty remainder and root
  assign lk_rem[0]  = '0;
  assign lk_root[0] = '0;

  // row of root cells, most significant root bit first
  for (genvar k = 0; k < RootW; k++) begin : g_cell
    tifv_root_cell #(
      .ROOT_W (RootW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lk_valid[k]),
      .ready_o (lk_ready[k]),
      .rem_i   (lk_rem[k]),
      .root_i  (lk_root[k]),
      .rad_i   (lk_rad[k]),
      .side_i  (lk_side[k]),
      .valid_o (lk_valid[k+1]),
      .ready_i (lk_ready[k+1]),
      .rem_o   (lk_rem[k+1]),
      .root_o  (lk_root[k+1]),
      .rad_o   (lk_rad[k+1]),
      .side_o  (lk_side[k+1])
    );
  end

  // back end: d^2 and r^2, then the field value with saturation
  logic signed [FIELD_W-1:0] field_value;
  logic [INDEX_W-1:0]        voxel_index;

  tifv_field #(
    .FRAC_BITS (FRAC_BITS),
    .ROOT_W    (RootW)
  ) u_field (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .outer_radius_i (outer_radius_q),
    .tube_radius_i  (tube_radius_q),
    .valid_i        (lk_valid[RootW]),
    .ready_o        (lk_ready[RootW]),
    .root_i         (lk_root[RootW]),
    .side_i         (lk_side[RootW]),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .field_value_o  (field_value),
    .voxel_index_o  (voxel_index),
    .out_of_range_o (m_axis_tuser)
  );

  assign m_axis_tdata = {voxel_index, field_value};

endmodule

### verif/tb_torus_implicit_field_voxel.sv
`timescale 1ns / 1ps

// voxel stream into the torus field block, results checked against a
// fixed-point predictor kept alongside the stimulus

module tb_torus_implicit_field_voxel;
  import tifv_pkg::*;

  // root cells plus the two front and two back stages
  localparam int LATENCY     = root_w(FRAC_BITS_DEF) + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int STREAM_LEN  = 230;
  localparam int MAX_REPORTS = 10;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  localparam longint FIELD_HI = (longint'(1) << (FIELD_W - 1)) - 1;
  localparam longint FIELD_LO = -(longint'(1) << (FIELD_W - 1));

  typedef struct {
    logic [FIELD_W-1:0] field;
    logic [INDEX_W-1:0] index;
    logic               oor;
  } voxel_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // coord_x, coord_y, coord_z
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // field_value, voxel_index
  logic                   m_axis_tuser;   // out_of_range

  // predictor's copy of the registers
  logic [GRID_W-1:0] grid_cfg;
  logic [RAD_W-1:0]  outer_cfg;
  logic [RAD_W-1:0]  tube_cfg;

  voxel_result_t voxel_results_q[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  int            src_idle_pct = 0;
  int            snk_stall_pct = 0;
  logic          hold_off = 1'b0;

  torus_implicit_field_voxel u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               voxel_results_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // grid size as the block uses it, clamped to the largest grid
  function automatic longint grid_span();
    return (grid_cfg > MAX_GRID_DEF) ? longint'(MAX_GRID_DEF) : longint'(grid_cfg);
  endfunction

  // floor of the square root, one result bit per step from the top
  function automatic longint floor_sqrt(input longint v);
    longint acc;
    longint trial;
    acc = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = acc | (longint'(1) << b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  function automatic voxel_result_t torus_field_at(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] z);
    voxel_result_t res;
    longint size, half, cx, cy, cz, sumsq, root, d, r, f, addr;
    res.field = '0;
    res.index = '0;
    res.oor   = 1'b0;
    size = grid_span();
    if (longint'(x) >= size || longint'(y) >= size || longint'(z) >= size) begin
      res.oor = 1'b1;
      return res;
    end
    // centre on floor(size / 2)
    half  = size >> 1;
    cx    = longint'(x) - half;
    cy    = longint'(y) - half;
    cz    = longint'(z) - half;
    sumsq = cx * cx + cy * cy;
    // root carries FRAC_BITS fractional bits, truncated
    root  = floor_sqrt(sumsq << (2 * FRAC_BITS_DEF));
    d     = longint'(outer_cfg) - root;
    r     = longint'(tube_cfg);
    f     = r * r - d * d - ((cz * cz) << (2 * FRAC_BITS_DEF));
    if (f > FIELD_HI) f = FIELD_HI;
    if (f < FIELD_LO) f = FIELD_LO;
    addr  = size * size * longint'(x) + size * longint'(y) + longint'(z);
    res.field = f[FIELD_W-1:0];
    res.index = addr[INDEX_W-1:0];
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // result side: check each beat, then decide the next stall
  task automatic check_voxel_beat();
    voxel_result_t      want;
    logic [FIELD_W-1:0] got_field;
    logic [INDEX_W-1:0] got_index;
    got_field = m_axis_tdata[FIELD_W-1:0];
    got_index = m_axis_tdata[FIELD_W +: INDEX_W];
    if (voxel_results_q.size() == 0) begin
      note_mismatch($sformatf("result beat with nothing outstanding: field %0d index %0d oor %0b",
                              $signed(got_field), got_index, m_axis_tuser));
      return;
    end
    want = voxel_results_q.pop_front();
    if (got_field !== want.field || got_index !== want.index || m_axis_tuser !== want.oor)
      note_mismatch($sformatf({"mismatch: field exp %0d got %0d, index exp %0d got %0d, ",
                               "oor exp %0b got %0b"},
                              $signed(want.field), $signed(got_field), want.index, got_index,
                              want.oor, m_axis_tuser));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_voxel_beat();
    m_axis_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic wait_for_results();
    while (voxel_results_q.size() != 0) @(posedge clk_i);
  endtask

  // one coordinate beat; valid stays up unless a gap is drawn after it
  task automatic send_voxel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - 3 * COORD_W){1'b0}}, z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    voxel_results_q.push_back(torus_field_at(x, y, z));
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // mostly voxels inside the grid, some noise over the whole coordinate range
  task automatic send_random_voxel();
    logic [COORD_W-1:0] c[3];
    longint             span;
    span = grid_span();
    for (int k = 0; k < 3; k++)
      c[k] = (span == 0) ? COORD_W'($urandom_range(511))
                         : COORD_W'($urandom_range(32'(span - 1)));
    if ($urandom_range(99) < 12) c[$urandom_range(2)] = COORD_W'($urandom_range(511));
    send_voxel(c[0], c[1], c[2]);
  endtask

  // writes all three registers back to back, optionally a stray index too,
  // only once the pipe is empty
  task automatic load_torus(input logic [CFG_DATA_W-1:0] grid,
                            input logic [CFG_DATA_W-1:0] outer,
                            input logic [CFG_DATA_W-1:0] tube,
                            input bit stray = 1'b0);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    int                    n;
    idx[0] = CFG_GRID_SIZE;
    val[0] = grid;
    idx[1] = CFG_NO_REG;
    val[1] = CFG_DATA_W'($urandom_range(16383));
    idx[2] = CFG_OUTER_RADIUS;
    val[2] = outer;
    idx[3] = CFG_TUBE_RADIUS;
    val[3] = tube;
    n = 0;
    wait_for_results();
    for (int i = 0; i < 4; i++) begin
      if (idx[i] == CFG_NO_REG && !stray) continue;
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        CFG_GRID_SIZE:    grid_cfg  = val[i][GRID_W-1:0];
        CFG_OUTER_RADIUS: outer_cfg = val[i][RAD_W-1:0];
        CFG_TUBE_RADIUS:  tube_cfg  = val[i][RAD_W-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // reset register values: corners, centre, a point on the ring, each
  // coordinate alone just past the grid and the top of the coordinate range
  task automatic test_reset_values();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_voxel(9'd0, 9'd0, 9'd0);
    send_voxel(9'd255, 9'd255, 9'd255);
    send_voxel(9'd128, 9'd128, 9'd128);
    send_voxel(9'd208, 9'd128, 9'd128);
    send_voxel(9'd256, 9'd0, 9'd0);
    send_voxel(9'd0, 9'd256, 9'd0);
    send_voxel(9'd0, 9'd0, 9'd256);
    send_voxel(9'd511, 9'd511, 9'd511);
    s_axis_tvalid <= 1'b0;
  endtask

  // largest grid, clamped grid, smallest in range, one and zero; a stray
  // register index rides along with two of the loads
  task automatic test_grid_sizes();
    load_torus(14'd512, 14'd1280, 14'd480, 1'b1);
    send_voxel(9'd511, 9'd511, 9'd511);
    send_voxel(9'd0, 9'd511, 9'd0);
    s_axis_tvalid <= 1'b0;
    load_torus(14'h3FFF, 14'd1280, 14'd480);
    send_voxel(9'd511, 9'd0, 9'd511);
    s_axis_tvalid <= 1'b0;
    load_torus(14'd10, 14'd80, 14'd80, 1'b1);
    send_voxel(9'd9, 9'd9, 9'd9);
    send_voxel(9'd10, 9'd0, 9'd0);
    send_voxel(9'd5, 9'd5, 9'd5);
    s_axis_tvalid <= 1'b0;
    load_torus(14'd1, 14'd80, 14'd8192);
    send_voxel(9'd0, 9'd0, 9'd0);
    send_voxel(9'd1, 9'd0, 9'd0);
    s_axis_tvalid <= 1'b0;
    load_torus(14'd0, 14'd80, 14'd8192);
    send_voxel(9'd0, 9'd0, 9'd0);
    s_axis_tvalid <= 1'b0;
  endtask

  // radii at both ends of the register width, driving the field into
  // negative saturation and up to its largest reachable value
  task automatic test_radius_extremes();
    load_torus(14'd512, 14'h3FFF, 14'd0);
    send_voxel(9'd256, 9'd256, 9'd0);
    send_voxel(9'd256, 9'd256, 9'd511);
    send_voxel(9'd0, 9'd0, 9'd0);
    s_axis_tvalid <= 1'b0;
    load_torus(14'd512, 14'd0, 14'h3FFF);
    send_voxel(9'd256, 9'd256, 9'd256);
    send_voxel(9'd511, 9'd0, 9'd255);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_random_stream(input int src_pct, input int snk_pct,
                                    input logic [CFG_DATA_W-1:0] grid,
                                    input logic [CFG_DATA_W-1:0] outer,
                                    input logic [CFG_DATA_W-1:0] tube);
    load_torus(grid, outer, tube);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    repeat (STREAM_LEN) send_random_voxel();
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver held off long enough for the pipe to fill and stall the input
  task automatic test_output_backpressure();
    load_torus(14'd512, CFG_DATA_W'($urandom_range(8192, 80)),
               CFG_DATA_W'($urandom_range(8192, 80)));
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    repeat (120) send_random_voxel();
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_GRID_SIZE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    grid_cfg  = GRID_SIZE_RST;
    outer_cfg = OUTER_RADIUS_RST;
    tube_cfg  = TUBE_RADIUS_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_grid_sizes();
    test_radius_extremes();
    test_random_stream(0, 0, 14'd512, 14'd1280, 14'd480);
    test_random_stream(88, 0, CFG_DATA_W'($urandom_range(512, 10)),
                       CFG_DATA_W'($urandom_range(8192, 80)),
                       CFG_DATA_W'($urandom_range(8192, 80)));
    test_random_stream(0, 88, 14'd10, 14'd8192, 14'd8192);
    test_random_stream(29, 29, CFG_DATA_W'($urandom_range(512, 10)),
                       CFG_DATA_W'($urandom_range(8192, 80)),
                       CFG_DATA_W'($urandom_range(8192, 80)));
    test_output_backpressure();

    wait_for_results();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
